>>> rtl/dpc_pkg.sv
`timescale 1ns / 1ps

package dpc_pkg;

    // Field widths fixed by the stream format
    localparam int CH_W     = 1;
    localparam int TS_W     = 32;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 32;
    localparam int LOCK_W   = 20;

    localparam int S_TDATA_W = 40;   // pin_level + timestamp_us, padded to bytes
    localparam int S_TUSER_W = 2;    // command + channel
    localparam int M_TDATA_W = 64;   // pulse_count + low_time_sum_us
    localparam int M_TUSER_W = 1;    // read_channel

    localparam int                CHANNELS_DEFAULT = 2;
    localparam logic [LOCK_W-1:0] LOCKOUT_RESET    = LOCK_W'(5000);

    // Item kind carried in tuser
    typedef enum logic {
        CMD_EVENT = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    // Per-channel state word held in the state memory
    typedef struct packed {
        logic             in_pulse;
        logic [TS_W-1:0]  last_time;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);

    // Saturating 32-bit add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/dpc_state_mem.sv
`timescale 1ns / 1ps

module dpc_state_mem #(
    parameter int CHANNELS = dpc_pkg::CHANNELS_DEFAULT
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
    input  logic                                               wr_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
    input  dpc_pkg::chan_entry_t                               wr_data,
    output dpc_pkg::chan_entry_t                               rd_entry
);
    import dpc_pkg::*;

    chan_entry_t                 mem [CHANNELS];
    logic        [CHANNELS-1:0]  valid_reg;
    chan_entry_t                 rd_data_reg;
    logic                        rd_valid_reg;
    logic                        byp_hit_reg;
    chan_entry_t                 byp_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Mark entries written since reset; unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Registered read, with a bypass for a write landing on the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    always_comb begin
        if (byp_hit_reg) begin
            rd_entry = byp_data_reg;
        end else if (rd_valid_reg) begin
            rd_entry = rd_data_reg;
        end else begin
            rd_entry = '0;
        end
    end

endmodule

>>> rtl/debounced_pulse_counter_core.sv
`timescale 1ns / 1ps

// Debounced pulse counter: qualifies active-low sensor pulses per channel and
// accumulates pulse count and low time. Each input transfer is either a pin
// level event (tuser command = event) or a read-and-clear of one channel's
// totals (command = read); only reads produce an output transfer. Items are
// accepted one per clock unless stalled: the channel state word is read from
// the state memory at acceptance, updated in stage 1 and written back, with a
// bypass so that back-to-back items on the same channel see the fresh state.
// A read result is registered in stage 1 and then in the output register. The
// input side stalls only while a read result waits in the output register and
// stage 1 also holds a read. After reset all channels start at zero, outside
// a pulse, with a lockout of 5000 us; events whose timestamp lies within the
// lockout of the last accepted transition (initially time zero) are dropped.
module debounced_pulse_counter_core #(
    parameter int CHANNELS = dpc_pkg::CHANNELS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [dpc_pkg::LOCK_W-1:0]    cfg_wr_data,   // debounce_lockout_us
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpc_pkg::S_TDATA_W-1:0] s_tdata,       // [0] pin_level, [32:1] timestamp_us
    input  logic [dpc_pkg::S_TUSER_W-1:0] s_tuser,       // [0] command, [1] channel
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpc_pkg::M_TDATA_W-1:0] m_tdata,       // [31:0] pulse_count, [63:32] low_time_sum_us
    output logic [dpc_pkg::M_TUSER_W-1:0] m_tuser        // [0] read_channel
);
    import dpc_pkg::*;

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [LOCK_W-1:0] lockout_reg;

    logic              s_accept;
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic [CH_W-1:0]   s1_ch_reg;
    logic              s1_level_reg;
    logic [TS_W-1:0]   s1_ts_reg;
    logic              s1_adv;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] s1_addr;
    chan_entry_t       cur;
    chan_entry_t       upd;
    logic              wr_en;

    logic              in_range;
    logic [TS_W-1:0]   phase;
    logic              pass;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CH_W-1:0]   out_ch_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [SUM_W-1:0]  out_sum_reg;

    // Lockout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_reg <= LOCKOUT_RESET;
        end else if (cfg_wr_en) begin
            lockout_reg <= cfg_wr_data;
        end
    end

    // Handshake: advance stage 1 unless a read must wait for the output register
    assign s1_adv   = s1_valid_reg && ((s1_cmd_reg != CMD_READ) || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    assign rd_addr = ADDR_W'(s_tuser[1]);
    assign s1_addr = ADDR_W'(s1_ch_reg);

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg   <= cmd_t'(s_tuser[0]);
            s1_ch_reg    <= s_tuser[1];
            s1_level_reg <= s_tdata[0];
            s1_ts_reg    <= s_tdata[TS_W:1];
        end
    end

    dpc_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr),
        .wr_data  (upd),
        .rd_entry (cur)
    );

    // Qualify the event and build the updated state word
    assign in_range = ({{(32-CH_W){1'b0}}, s1_ch_reg} < 32'(CHANNELS));
    assign phase    = s1_ts_reg - cur.last_time;
    assign pass     = (s1_cmd_reg == CMD_EVENT) && in_range
                   && (phase >= {{(TS_W-LOCK_W){1'b0}}, lockout_reg})
                   && (s1_level_reg == cur.in_pulse);

    always_comb begin
        upd   = cur;
        wr_en = 1'b0;
        if (s1_adv && in_range) begin
            if (s1_cmd_reg == CMD_READ) begin
                upd.count = '0;
                upd.sum   = '0;
                wr_en     = 1'b1;
            end else if (pass) begin
                upd.last_time = s1_ts_reg;
                upd.in_pulse  = ~cur.in_pulse;
                if (s1_level_reg) begin
                    upd.count = sat_add(cur.count, CNT_W'(1));
                    upd.sum   = sat_add(cur.sum, phase);
                end
                wr_en = 1'b1;
            end
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (s1_adv && (s1_cmd_reg == CMD_READ)) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && (s1_cmd_reg == CMD_READ)) begin
            out_ch_reg    <= s1_ch_reg;
            out_count_reg <= in_range ? cur.count : '0;
            out_sum_reg   <= in_range ? cur.sum : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sum_reg, out_count_reg};
    assign m_tuser  = out_ch_reg;

    logic [S_TDATA_W-TS_W-2:0] unused_pad;
    assign unused_pad = s_tdata[S_TDATA_W-1:TS_W+1];

endmodule
